### sv/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types, widths and codes for the triangle rasteriser with depth test.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Field widths
  localparam int COORD_W   = 13;
  localparam int Z_W       = 32;
  localparam int COLOR_W   = 24;
  localparam int ACT_W     = 2;
  localparam int OUT_XY_W  = 9;
  localparam int SCREEN_W  = 10;

  // Cross products of two coordinate differences, and the depth numerator
  localparam int CRW       = 2 * (COORD_W + 1);
  localparam int NUM_W     = 64;

  // Stream and register port widths
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_FRAC_BITS  = 4;

  localparam int SCREEN_RESET = 512;

  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};
  localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};

  // Request kinds on tuser
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STEP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CU,
    ST_CV,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_ACC,
    ST_DIV,
    ST_DIVW,
    ST_WB
  } trd_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } trd_div_stat_t;

endpackage

### sv/trd_div.sv
// ----------------------------------------------------------------------------
// trd_div
// Restoring divider, one quotient bit a cycle: signed numerator over signed
// area, truncated toward zero and saturated to a 32-bit depth.
// ----------------------------------------------------------------------------
module trd_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [trd_pkg::NUM_W-1:0]     num,
  input  logic signed [trd_pkg::CRW-1:0]       den,
  output trd_pkg::trd_div_stat_t               stat,
  output logic signed [trd_pkg::Z_W-1:0]       quot
);
  import trd_pkg::*;

  localparam int CNT_W = $clog2(Z_W);

  logic [NUM_W-1:0] n_mag;
  logic [CRW-1:0]   d_mag;
  logic             big;

  logic [CRW-1:0]   rem_r, rem_nxt;
  logic [CRW-1:0]   den_r;
  logic [Z_W-1:0]   nlo_r;
  logic [Z_W-1:0]   q_r;
  logic             big_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [CRW:0]     r2;
  logic             ge;

  // Operand magnitudes; a quotient of 2^32 or more is saturated at once
  assign n_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign d_mag = den[CRW-1] ? CRW'(-den) : CRW'(den);
  assign big   = n_mag[NUM_W-1:Z_W] >= Z_W'(d_mag);

  // One trial subtraction
  assign r2      = {rem_r, nlo_r[Z_W-1]};
  assign ge      = r2 >= {1'b0, den_r};
  assign rem_nxt = ge ? CRW'(r2 - {1'b0, den_r}) : r2[CRW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Z_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= n_mag[Z_W +: CRW];
      nlo_r <= n_mag[Z_W-1:0];
      den_r <= d_mag;
      big_r <= big;
      neg_r <= num[NUM_W-1] ^ den[CRW-1];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      nlo_r <= nlo_r << 1;
      q_r   <= {q_r[Z_W-2:0], ge};
    end
  end

  // Sign and saturation
  always_comb begin
    if (neg_r) begin
      if (big_r || q_r > Z_W'(Z_MIN)) quot = Z_MIN;
      else                            quot = -$signed(q_r);
    end else begin
      if (big_r || q_r > Z_W'(Z_MAX)) quot = Z_MAX;
      else                            quot = $signed(q_r);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### sv/triangle_raster_depth_test.sv
// ----------------------------------------------------------------------------
// triangle_raster_depth_test
// Barycentric triangle rasteriser with a depth buffer test.
// ----------------------------------------------------------------------------
// Usage:
//  in_ (tdata/tuser) takes one request at a time: tuser = 0 loads a triangle,
//  1 steps to the next pixel of its raster box, 2 clears the depth store.
//  A step while no box is active, and kind 3, are dropped.
//  out_ gives one pixel result per step; tlast marks the last box pixel and
//  tuser flags a pixel that passed the test and was written to the store.
//  A step forms the cross products and reads the depth store, then runs three
//  products through one shared 30x32 multiplier and a bit-serial divider,
//  then compares and writes back to the store. A zero-area triangle skips
//  the products and the divider.
//  The depth store is one synchronous RAM of MAX_WIDTH*MAX_HEIGHT words.
//  After reset, and for every clear request, a sweep writes the most negative
//  depth to each word, one a cycle; no request is taken meanwhile, register
//  writes are.
//  A result held by a stalled receiver stalls the next step at write-back;
//  loads and clears are still taken once the block is idle.
//  Registers: screen_width at 0x0, screen_height at 0x4; both reset to 512.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test #(
  parameter int MAX_WIDTH  = trd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = trd_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = trd_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, color, zero pad
  input  logic [trd_pkg::IN_DATA_W-1:0]      in_tdata,
  // action
  input  logic [trd_pkg::ACT_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pixel_x, pixel_y, pixel_depth, pixel_color, zero pad
  output logic [trd_pkg::OUT_DATA_W-1:0]     out_tdata,
  // drawn
  output logic [0:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [trd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [trd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [trd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import trd_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = COORD_W - FRAC_BITS;
  localparam int WW    = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int CW    = WW > SCREEN_W ? WW : SCREEN_W;
  localparam int EW    = (CW > PW ? CW : PW) + 1;
  localparam int IXW   = (AW > PW + CW + 1) ? AW : PW + CW + 1;
  localparam int WSUM  = CRW + 2;
  localparam int PRW   = WSUM + Z_W;

  // --------------------------------------------------------------------------
  // Configuration
  logic [SCREEN_W-1:0] scr_w_r, scr_h_r;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_W'(SCREEN_RESET);
      scr_h_r <= SCREEN_W'(SCREEN_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_WIDTH:  scr_w_r <= cfg_pwdata[SCREEN_W-1:0];
        REG_HEIGHT: scr_h_r <= cfg_pwdata[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_WIDTH:  cfg_prdata = CFG_DATA_W'(scr_w_r);
      REG_HEIGHT: cfg_prdata = CFG_DATA_W'(scr_h_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Effective screen size, capped at the store size
  logic [CW-1:0] eff_w, eff_h;
  assign eff_w = (CW'(scr_w_r) < CW'(MAX_WIDTH))  ? CW'(scr_w_r) : CW'(MAX_WIDTH);
  assign eff_h = (CW'(scr_h_r) < CW'(MAX_HEIGHT)) ? CW'(scr_h_r) : CW'(MAX_HEIGHT);

  // --------------------------------------------------------------------------
  // Input fields
  logic [COORD_W-1:0]     in_x [3];
  logic [COORD_W-1:0]     in_y [3];
  logic signed [Z_W-1:0]  in_z [3];
  logic [COLOR_W-1:0]     in_color;
  localparam int VTX_W = 2 * COORD_W + Z_W;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_x[i] = in_tdata[i*VTX_W +: COORD_W];
      in_y[i] = in_tdata[i*VTX_W + COORD_W +: COORD_W];
      in_z[i] = in_tdata[i*VTX_W + 2*COORD_W +: Z_W];
    end
    in_color = in_tdata[3*VTX_W +: COLOR_W];
  end

  // --------------------------------------------------------------------------
  // Control
  trd_state_t state_r, state_nxt;
  logic       in_acc;
  logic       commit;
  logic       div_start;
  logic       active_r;
  logic       clr_done;
  logic [AW-1:0] clr_addr_r;
  logic       out_valid_r;
  trd_div_stat_t div_stat;
  logic signed [CRW-1:0] area_r;

  assign in_acc   = in_tvalid && in_tready;
  assign clr_done = clr_addr_r == AW'(CELLS - 1);
  assign commit   = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ACT_CLEAR) state_nxt = ST_CLEAR;
          else if (in_tuser == ACT_STEP && active_r) state_nxt = ST_CU;
        end
      end
      ST_CU:   state_nxt = ST_CV;
      ST_CV:   state_nxt = (area_r == '0) ? ST_WB : ST_M0;
      ST_M0:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_DIVW;
      ST_DIVW: if (div_stat.done) state_nxt = ST_WB;
      ST_WB:   if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_DIV:  div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      else                     clr_addr_r <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Triangle set-up on a load
  logic [COORD_W-1:0]    vx_r [3];
  logic [COORD_W-1:0]    vy_r [3];
  logic signed [Z_W-1:0] vz_r [3];
  logic [COLOR_W-1:0]    color_r;
  logic [PW-1:0]         bx0_r, by0_r, bx1_r, by1_r;
  logic [PW-1:0]         px_r, py_r;

  logic [COORD_W-1:0]    min_x, min_y, max_x, max_y;
  logic signed [COORD_W:0] l_ax, l_ay, l_bx, l_by;
  logic signed [CRW:0]   l_area;
  logic                  load;

  assign load = in_acc && in_tuser == ACT_LOAD;

  always_comb begin
    min_x = in_x[0]; max_x = in_x[0];
    min_y = in_y[0]; max_y = in_y[0];
    for (int i = 1; i < 3; i++) begin
      if (in_x[i] < min_x) min_x = in_x[i];
      if (in_x[i] > max_x) max_x = in_x[i];
      if (in_y[i] < min_y) min_y = in_y[i];
      if (in_y[i] > max_y) max_y = in_y[i];
    end
  end

  assign l_ax   = $signed({1'b0, in_x[2]}) - $signed({1'b0, in_x[0]});
  assign l_ay   = $signed({1'b0, in_y[2]}) - $signed({1'b0, in_y[0]});
  assign l_bx   = $signed({1'b0, in_x[1]}) - $signed({1'b0, in_x[0]});
  assign l_by   = $signed({1'b0, in_y[1]}) - $signed({1'b0, in_y[0]});
  assign l_area = (CRW+1)'(l_ax * l_by) - (CRW+1)'(l_ay * l_bx);

  // Raster walk: next pixel in row order
  logic [PW:0] px_inc, py_inc;
  assign px_inc = {1'b0, px_r} + 1'b1;
  assign py_inc = {1'b0, py_r} + 1'b1;
  logic row_end, box_end;
  assign row_end = !(px_inc < {1'b0, bx1_r});
  assign box_end = row_end && !(py_inc < {1'b0, by1_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= (min_x[COORD_W-1:FRAC_BITS] < max_x[COORD_W-1:FRAC_BITS]) &&
                  (min_y[COORD_W-1:FRAC_BITS] < max_y[COORD_W-1:FRAC_BITS]);
    end else if (state_r == ST_WB && commit && box_end) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= in_x[i];
        vy_r[i] <= in_y[i];
        vz_r[i] <= in_z[i];
      end
      color_r <= in_color;
      area_r  <= l_area[CRW-1:0];
      bx0_r   <= min_x[COORD_W-1:FRAC_BITS];
      by0_r   <= min_y[COORD_W-1:FRAC_BITS];
      bx1_r   <= max_x[COORD_W-1:FRAC_BITS];
      by1_r   <= max_y[COORD_W-1:FRAC_BITS];
      px_r    <= min_x[COORD_W-1:FRAC_BITS];
      py_r    <= min_y[COORD_W-1:FRAC_BITS];
    end else if (state_r == ST_WB && commit) begin
      if (!row_end) begin
        px_r <= px_inc[PW-1:0];
      end else begin
        px_r <= bx0_r;
        if (!box_end) py_r <= py_inc[PW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel datapath
  logic signed [COORD_W:0] ax, ay, bx, by, qx, qy;
  logic [COORD_W-1:0]      px_fx, py_fx;

  assign px_fx = COORD_W'(px_r) << FRAC_BITS;
  assign py_fx = COORD_W'(py_r) << FRAC_BITS;
  assign ax = $signed({1'b0, vx_r[2]}) - $signed({1'b0, vx_r[0]});
  assign ay = $signed({1'b0, vy_r[2]}) - $signed({1'b0, vy_r[0]});
  assign bx = $signed({1'b0, vx_r[1]}) - $signed({1'b0, vx_r[0]});
  assign by = $signed({1'b0, vy_r[1]}) - $signed({1'b0, vy_r[0]});
  assign qx = $signed({1'b0, px_fx}) - $signed({1'b0, vx_r[0]});
  assign qy = $signed({1'b0, py_fx}) - $signed({1'b0, vy_r[0]});

  logic signed [CRW:0]   cu_calc, cv_calc;
  logic signed [CRW-1:0] cu_r, cv_r;
  assign cu_calc = (CRW+1)'(ax * qy) - (CRW+1)'(ay * qx);
  assign cv_calc = (CRW+1)'(qx * by) - (CRW+1)'(qy * bx);

  // Weight of the first vertex and the inside test
  logic signed [WSUM-1:0] w0, cuv, a_ext;
  assign cuv   = WSUM'(cu_r) + WSUM'(cv_r);
  assign a_ext = WSUM'(area_r);
  assign w0    = a_ext - cuv;

  logic inside_r;
  logic inside_calc;
  always_comb begin
    if (!area_r[CRW-1])
      inside_calc = !cu_r[CRW-1] && !cv_r[CRW-1] && (cuv <= a_ext);
    else
      inside_calc = (cu_r <= 0) && (cv_r <= 0) && (cuv >= a_ext);
  end

  // Shared multiplier for the depth numerator
  logic signed [WSUM-1:0] mul_a;
  logic signed [Z_W-1:0]  mul_b;
  logic signed [PRW-1:0]  prod_r;
  logic signed [NUM_W-1:0] acc_r;

  always_comb begin
    case (state_r)
      ST_M1:   begin mul_a = WSUM'(cu_r); mul_b = vz_r[1]; end
      ST_M2:   begin mul_a = WSUM'(cv_r); mul_b = vz_r[2]; end
      default: begin mul_a = w0;          mul_b = vz_r[0]; end
    endcase
  end

  // Store index and clip
  logic [PW+CW-1:0] row_base;
  logic [IXW-1:0]   idx_sum;
  logic [AW-1:0]    idx_r;
  logic             onscr_r;
  assign row_base = (PW+CW)'(py_r) * (PW+CW)'(eff_w);
  assign idx_sum  = IXW'(row_base) + IXW'(px_r);

  logic signed [Z_W-1:0] z_r;
  logic signed [Z_W-1:0] div_q;

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_CU: begin
        cu_r    <= cu_calc[CRW-1:0];
        idx_r   <= idx_sum[AW-1:0];
        onscr_r <= (EW'(px_r) < EW'(eff_w)) && (EW'(py_r) < EW'(eff_h));
      end
      ST_CV: begin
        cv_r     <= cv_calc[CRW-1:0];
        z_r      <= '0;
        inside_r <= 1'b0;
      end
      ST_M0: begin
        prod_r   <= mul_a * mul_b;
        inside_r <= inside_calc;
      end
      ST_M1: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= NUM_W'(prod_r);
      end
      ST_M2: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= acc_r + NUM_W'(prod_r);
      end
      ST_ACC:  acc_r <= acc_r + NUM_W'(prod_r);
      ST_DIVW: if (div_stat.done) z_r <= div_q;
      default: ;
    endcase
  end

  trd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (area_r),
    .stat  (div_stat),
    .quot  (div_q)
  );

  // --------------------------------------------------------------------------
  // Depth store: read with the second cross product, write back on commit
  logic signed [Z_W-1:0] depth_mem [CELLS];
  logic signed [Z_W-1:0] stored_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [Z_W-1:0] mem_wdata;
  logic                  draw;

  assign draw = inside_r && onscr_r && (z_r > stored_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = z_r;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = Z_MIN;
    end else if (state_r == ST_WB && commit && draw) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
    if (state_r == ST_CV) stored_r <= depth_mem[idx_r];
  end

  // --------------------------------------------------------------------------
  // Result register
  logic [OUT_XY_W-1:0]   ox_r, oy_r;
  logic signed [Z_W-1:0] oz_r;
  logic [COLOR_W-1:0]    ocol_r;
  logic                  odrawn_r, olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_WB && commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WB && commit) begin
      ox_r     <= OUT_XY_W'(px_r);
      oy_r     <= OUT_XY_W'(py_r);
      oz_r     <= z_r;
      ocol_r   <= color_r;
      odrawn_r <= draw;
      olast_r  <= box_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({ocol_r, oz_r, oy_r, ox_r});
  assign out_tuser  = odrawn_r;
  assign out_tlast  = olast_r;

  // --------------------------------------------------------------------------
  // Checks
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIVW)
    else $error("divider finished outside its wait state");

  a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIVW)
    else $error("divider running outside its wait state");

  a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_WB))
    else $error("result raised without a write-back");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_raster_depth_test. A scoreboard class keeps
// its own copy of the rasteriser and depth store, predicts each pixel result
// from the accepted requests and checks the results field by field. Stimulus
// is a directed opening followed by random triangles and steps under several
// screen sizes, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trd_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int CELLS      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int IDLE_LIMIT = 1000000;
  localparam int FB         = DEF_FRAC_BITS;

  typedef struct {
    logic [8:0]        px;
    logic [8:0]        py;
    logic signed [31:0] depth;
    logic [23:0]       color;
    logic              drawn;
    logic              last;
  } pixel_t;

  // Scoreboard: rasteriser copy plus queue of awaited pixels
  class raster_scoreboard;
    int          depth_mem [CELLS];
    longint      vx [3];
    longint      vy [3];
    longint      vz [3];
    longint      area;
    int          box_x0, box_y0, box_x1, box_y1;
    int          pos_x, pos_y;
    logic [23:0] color;
    bit          active;
    int          scr_w, scr_h;
    pixel_t      awaited [$];
    int          errors;

    function void clear_depth();
      foreach (depth_mem[i]) depth_mem[i] = int'(Z_MIN);
    endfunction

    function void init();
      clear_depth();
      foreach (vx[i]) begin
        vx[i] = 0; vy[i] = 0; vz[i] = 0;
      end
      area = 0; box_x0 = 0; box_y0 = 0; box_x1 = 0; box_y1 = 0;
      pos_x = 0; pos_y = 0; color = '0; active = 0;
      scr_w = SCREEN_RESET; scr_h = SCREEN_RESET; errors = 0;
    endfunction

    function void load(logic [IN_DATA_W-1:0] d);
      for (int i = 0; i < 3; i++) begin
        vx[i] = longint'(d[58*i +: 13]);
        vy[i] = longint'(d[58*i + 13 +: 13]);
        vz[i] = longint'($signed(d[58*i + 26 +: 32]));
      end
      color = d[174 +: 24];
      area = (vx[2]-vx[0])*(vy[1]-vy[0]) - (vy[2]-vy[0])*(vx[1]-vx[0]);
      box_x0 = int'((vx[0] < vx[1] ? (vx[0] < vx[2] ? vx[0] : vx[2])
                                  : (vx[1] < vx[2] ? vx[1] : vx[2])) >> FB);
      box_y0 = int'((vy[0] < vy[1] ? (vy[0] < vy[2] ? vy[0] : vy[2])
                                  : (vy[1] < vy[2] ? vy[1] : vy[2])) >> FB);
      box_x1 = int'((vx[0] > vx[1] ? (vx[0] > vx[2] ? vx[0] : vx[2])
                                  : (vx[1] > vx[2] ? vx[1] : vx[2])) >> FB);
      box_y1 = int'((vy[0] > vy[1] ? (vy[0] > vy[2] ? vy[0] : vy[2])
                                  : (vy[1] > vy[2] ? vy[1] : vy[2])) >> FB);
      pos_x = box_x0;
      pos_y = box_y0;
      active = (box_x0 < box_x1) && (box_y0 < box_y1);
    endfunction

    function void step();
      pixel_t p;
      longint qx, qy, cu, cv, z;
      bit in_tri;
      int w, h, idx;
      z = 0;
      in_tri = 0;
      if (area != 0) begin
        qx = (longint'(pos_x) << FB) - vx[0];
        qy = (longint'(pos_y) << FB) - vy[0];
        cu = (vx[2]-vx[0])*qy - (vy[2]-vy[0])*qx;
        cv = qx*(vy[1]-vy[0]) - qy*(vx[1]-vx[0]);
        if (area > 0) in_tri = cu >= 0 && cv >= 0 && cu + cv <= area;
        else          in_tri = cu <= 0 && cv <= 0 && cu + cv >= area;
        z = ((area - cu - cv)*vz[0] + cu*vz[1] + cv*vz[2]) / area;
        if (z > 64'sd2147483647)  z = 64'sd2147483647;
        if (z < -64'sd2147483648) z = -64'sd2147483648;
      end
      w = scr_w < DEF_MAX_WIDTH  ? scr_w : DEF_MAX_WIDTH;
      h = scr_h < DEF_MAX_HEIGHT ? scr_h : DEF_MAX_HEIGHT;
      p.px = pos_x[8:0];
      p.py = pos_y[8:0];
      p.depth = z[31:0];
      p.color = color;
      p.drawn = 0;
      p.last = 0;
      if (in_tri && pos_x < w && pos_y < h) begin
        idx = pos_y * w + pos_x;
        if (z > longint'(depth_mem[idx])) begin
          depth_mem[idx] = int'(z);
          p.drawn = 1;
        end
      end
      if (pos_x + 1 < box_x1) pos_x++;
      else begin
        pos_x = box_x0;
        if (pos_y + 1 < box_y1) pos_y++;
        else begin
          active = 0;
          p.last = 1;
        end
      end
      awaited.push_back(p);
    endfunction

    // Accepted input request
    function void note_request(logic [ACT_W-1:0] act, logic [IN_DATA_W-1:0] d);
      case (act)
        ACT_LOAD:  load(d);
        ACT_CLEAR: clear_depth();
        ACT_STEP:  if (active) step();
        default: ;
      endcase
    endfunction

    // Accepted result against the oldest awaited pixel
    function void check_result(logic [OUT_DATA_W-1:0] d, logic drawn, logic last);
      pixel_t e;
      if (awaited.size() == 0) begin
        $error("unexpected pixel result %h", d);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (d[8:0] !== e.px) begin
        $error("pixel_x exp %0d got %0d", e.px, d[8:0]); errors++;
      end
      if (d[17:9] !== e.py) begin
        $error("pixel_y exp %0d got %0d", e.py, d[17:9]); errors++;
      end
      if (d[49:18] !== e.depth) begin
        $error("pixel_depth exp %0d got %0d", e.depth, $signed(d[49:18])); errors++;
      end
      if (d[73:50] !== e.color) begin
        $error("pixel_color exp %h got %h", e.color, d[73:50]); errors++;
      end
      if (drawn !== e.drawn) begin
        $error("drawn exp %0d got %0d", e.drawn, drawn); errors++;
      end
      if (last !== e.last) begin
        $error("last_pixel exp %0d got %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel = 0;
  logic                  cfg_penable = 0;
  logic                  cfg_pwrite = 0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  raster_scoreboard sb = new();
  bit  hold_out = 0;
  int  idle_cycles = 0;
  int  last_xy [6];
  int  coord_ceil = 8191;

  triangle_raster_depth_test uut (.*);

  always #5 clk = ~clk;

  // Request and result monitors
  always @(posedge clk)
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0], out_tlast);

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on demand
  initial begin
    int r;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_out = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) out_tready <= 1;
        else if (r < 96) out_tready <= 0;
        else begin
          out_tready <= 0;
          repeat ($urandom_range(10, 80)) @(posedge clk);
        end
      end
    end
  end

  task automatic send(logic [ACT_W-1:0] act, logic [IN_DATA_W-1:0] d);
    int r;
    in_tvalid <= 1;
    in_tuser <= act;
    in_tdata <= d;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    r = $urandom_range(0, 99);
    if (r >= 55) begin
      in_tvalid <= 0;
      repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(20, 120)) @(posedge clk);
    end
  endtask

  task automatic send_step();
    send(ACT_STEP, IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom}));
  endtask

  task automatic send_load(int x0, int y0, int z0, int x1, int y1, int z1,
                           int x2, int y2, int z2, int col);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[0 +: 13] = 13'(x0);   d[13 +: 13] = 13'(y0);   d[26 +: 32] = z0;
    d[58 +: 13] = 13'(x1);  d[71 +: 13] = 13'(y1);   d[84 +: 32] = z1;
    d[116 +: 13] = 13'(x2); d[129 +: 13] = 13'(y2);  d[142 +: 32] = z2;
    d[174 +: 24] = 24'(col);
    send(ACT_LOAD, d);
  endtask

  // Random triangle near a random spot; sometimes reuses the last corners
  task automatic random_load();
    int span, bx, by;
    if ($urandom_range(0, 5) == 0) begin
      send_load(last_xy[0], last_xy[1], $urandom, last_xy[2], last_xy[3], $urandom,
                last_xy[4], last_xy[5], $urandom, $urandom_range(0, 24'hFFFFFF));
      return;
    end
    span = ($urandom_range(0, 19) == 0) ? coord_ceil : $urandom_range(16, 96);
    if (span > coord_ceil) span = coord_ceil;
    bx = $urandom_range(0, coord_ceil - span);
    by = $urandom_range(0, coord_ceil - span);
    for (int i = 0; i < 3; i++) begin
      last_xy[2*i]   = bx + $urandom_range(0, span);
      last_xy[2*i+1] = by + $urandom_range(0, span);
    end
    send_load(last_xy[0], last_xy[1], $urandom, last_xy[2], last_xy[3], $urandom,
              last_xy[4], last_xy[5], $urandom, $urandom_range(0, 24'hFFFFFF));
  endtask

  task automatic drain();
    in_tvalid <= 0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, int value);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == REG_WIDTH) sb.scr_w = value & 32'h3FF;
    else                  sb.scr_h = value & 32'h3FF;
  endtask

  task automatic cfg_check(logic idx, int value);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 0; cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    if (cfg_prdata[9:0] !== value[9:0]) begin
      $error("register %0d exp %0d got %0d", idx, value, cfg_prdata); sb.errors++;
    end
    cfg_psel <= 0; cfg_penable <= 0;
  endtask

  task automatic set_screen(int w, int h);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_check(REG_WIDTH, w);
    cfg_check(REG_HEIGHT, h);
  endtask

  // Random phase: mostly loads and steps, a little noise
  task automatic random_phase(int n, int ceil_val, bit stall_out);
    int r;
    coord_ceil = ceil_val;
    for (int i = 0; i < n; i++) begin
      if (stall_out && i == n / 2) hold_out = 1;
      r = $urandom_range(0, 99);
      if (r < 14) random_load();
      else if (r < 97) send_step();
      else send(ACT_SPARE, IN_DATA_W'({7{$urandom}}));
    end
    drain();
  endtask

  initial begin
    sb.init();
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Directed: reset values, ignored requests, empty box
    cfg_check(REG_WIDTH, SCREEN_RESET);
    cfg_check(REG_HEIGHT, SCREEN_RESET);
    send_step();
    send(ACT_SPARE, '1);
    send_load(16, 16, 0, 17, 20, 0, 31, 31, 0, 24'h123456);
    send_step();
    // Field extremes, whole screen box
    send_load(0, 0, int'(Z_MAX), 8191, 8191, int'(Z_MIN), 0, 8191, 0, 24'hFFFFFF);
    repeat (2) send_step();
    // Zero area
    send_load(16, 16, 100, 48, 48, 200, 80, 80, 300, 24'h00FF00);
    repeat (3) send_step();
    // Negative area, run to the end, then a step while idle
    send_load(0, 0, 32'h0001_0000, 48, 0, 32'h0002_0000, 0, 48, 32'h0003_0000, 24'hABCDEF);
    repeat (9) send_step();
    send_step();
    // Same triangle further away: depth test fails; clear mid-raster
    send_load(0, 0, -5, 48, 0, -5, 0, 48, -5, 24'h000001);
    repeat (3) send_step();
    send(ACT_CLEAR, '0);
    repeat (6) send_step();
    drain();

    // Random phases across screen settings
    random_phase(100, 8191, 1);
    set_screen(1, 1);
    random_phase(60, 300, 0);
    set_screen(0, 1023);
    random_phase(60, 600, 0);
    set_screen($urandom_range(20, 100), $urandom_range(20, 100));
    random_phase(100, 1800, 0);
    set_screen(1023, 512);
    random_phase(60, 8191, 0);
    // Sender pause until all results are in, then more
    set_screen(512, 1);
    random_phase(70, 8191, 0);

    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
